// ----- rtl/core/msu_pkg.sv -----
// Shared types, operation codes and constants of the VM memory and stack unit.
`timescale 1ns / 1ps
package msu_pkg;

	// Default store size in bytes
	localparam int MEM_BYTES_DEFAULT = 65536;

	// Stack pointer value after reset
	localparam logic [31:0] STACK_BASE_RESET = 32'h0001_0000;

	// Operation codes
	localparam logic [3:0] OP_RDBYTE = 4'd0;
	localparam logic [3:0] OP_WRBYTE = 4'd1;
	localparam logic [3:0] OP_RDWORD = 4'd2;
	localparam logic [3:0] OP_WRWORD = 4'd3;
	localparam logic [3:0] OP_FETCHB = 4'd4;
	localparam logic [3:0] OP_FETCHW = 4'd5;
	localparam logic [3:0] OP_PUSH   = 4'd6;
	localparam logic [3:0] OP_POP    = 4'd7;
	localparam logic [3:0] OP_FLAGS  = 4'd8;

	// Flag bit positions in the flags byte
	localparam int FLAG_SIGN   = 7;
	localparam int FLAG_ZERO   = 6;
	localparam int FLAG_PARITY = 2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;     // input transfer this cycle: decode, update state, start access
		logic load_out;   // finished item moves into the output register
		logic clear_step; // clearing pass writes one row of every bank
	} msu_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic clear_last; // clearing pass is on its final row
	} msu_sts_t;

endpackage

// ----- rtl/core/msu_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module msu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/msu_ctrl.sv -----
// Controller state machine: clearing pass, item sequencing and output valid.
`timescale 1ns / 1ps
module msu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output msu_pkg::msu_cmd_t cmd,
	input  msu_pkg::msu_sts_t sts
);
	import msu_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	// Handshake and commands
	assign in_stall       = (state_q != ST_IDLE);
	assign out_free       = !out_valid_q || !out_stall;
	assign cmd.accept     = in_valid && (state_q == ST_IDLE);
	assign cmd.load_out   = (state_q == ST_EXEC) && out_free;
	assign cmd.clear_step = (state_q == ST_CLEAR);
	assign out_valid      = out_valid_q;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.accept) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (cmd.load_out) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/core/msu_datapath.sv -----
// Datapath: four byte banks, address and range logic, PC/SP/flags and output register.
`timescale 1ns / 1ps
module msu_datapath #(
	parameter int MEM_BYTES = msu_pkg::MEM_BYTES_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  msu_pkg::msu_cmd_t cmd,
	output msu_pkg::msu_sts_t sts,
	input  logic [3:0]        operation,
	input  logic [31:0]       address,
	input  logic [31:0]       data,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	output logic [31:0]       read_data,
	output logic              out_of_range,
	output logic [31:0]       program_counter,
	output logic [31:0]       stack_pointer,
	output logic [7:0]        flag_bits
);
	import msu_pkg::*;

	localparam int          ROWS      = (MEM_BYTES + 3) / 4;
	localparam int          ROW_W     = $clog2(ROWS);
	localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	// Architectural state
	logic [31:0]      pc_q;
	logic [31:0]      sp_q;
	logic [7:0]       flags_q;
	logic [ROW_W-1:0] clr_row_q;

	// Access context carried into the read cycle
	logic [1:0] off_s1;
	logic       word_s1;
	logic       rd_en_s1;
	logic       bad_s1;

	// Output register
	logic [31:0] read_data_q;
	logic        out_of_range_q;
	logic [31:0] pc_out_q;
	logic [31:0] sp_out_q;
	logic [7:0]  flags_out_q;

	// Decode
	logic [31:0]      ea;
	logic             acc_word;
	logic             acc_rd;
	logic             acc_wr;
	logic [31:0]      pc_nxt;
	logic [31:0]      sp_nxt;
	logic [7:0]       flags_nxt;
	logic [32:0]      ea_end;
	logic             in_range;
	logic [ROW_W-1:0] row0;
	logic [ROW_W-1:0] row1;

	// Bank ports
	logic             bank_we    [4];
	logic [ROW_W-1:0] bank_addr  [4];
	logic [7:0]       bank_wdata [4];
	logic [7:0]       bank_rdata [4];
	logic [7:0]       lane       [4];
	logic [31:0]      rd_value;

	// Operation decode and next state of PC, SP and flags
	always_comb begin
		ea        = address;
		acc_word  = 1'b0;
		acc_rd    = 1'b0;
		acc_wr    = 1'b0;
		pc_nxt    = pc_q;
		sp_nxt    = sp_q;
		flags_nxt = flags_q;
		case (operation)
			OP_RDBYTE: acc_rd = 1'b1;
			OP_WRBYTE: acc_wr = 1'b1;
			OP_RDWORD: begin
				acc_rd   = 1'b1;
				acc_word = 1'b1;
			end
			OP_WRWORD: begin
				acc_wr   = 1'b1;
				acc_word = 1'b1;
			end
			OP_FETCHB: begin
				ea     = pc_q;
				acc_rd = 1'b1;
				pc_nxt = pc_q + 32'd1;
			end
			OP_FETCHW: begin
				ea       = pc_q;
				acc_rd   = 1'b1;
				acc_word = 1'b1;
				pc_nxt   = pc_q + 32'd4;
			end
			OP_PUSH: begin
				ea       = sp_q - 32'd4;
				acc_wr   = 1'b1;
				acc_word = 1'b1;
				sp_nxt   = sp_q - 32'd4;
			end
			OP_POP: begin
				ea       = sp_q;
				acc_rd   = 1'b1;
				acc_word = 1'b1;
				sp_nxt   = sp_q + 32'd4;
			end
			OP_FLAGS: begin
				flags_nxt              = 8'h00;
				flags_nxt[FLAG_ZERO]   = (data == 32'd0);
				flags_nxt[FLAG_SIGN]   = data[31];
				flags_nxt[FLAG_PARITY] = ~^data;
			end
			default: ;
		endcase
	end

	// Range check on the last byte touched, without wrap
	assign ea_end   = {1'b0, ea} + (acc_word ? 33'd3 : 33'd0);
	assign in_range = (ea_end < MEM_LIMIT);
	assign row0     = ea[ROW_W+1:2];
	assign row1     = row0 + ROW_W'(1);

	// Bank steering: lane k of a word lives in bank (ea + k) mod 4
	always_comb begin
		logic [1:0] k;
		for (int b = 0; b < 4; b++) begin
			k = 2'(b) - ea[1:0];
			bank_addr[b]  = (2'(b) >= ea[1:0]) ? row0 : row1;
			bank_wdata[b] = data[8*k +: 8];
			bank_we[b]    = cmd.accept && acc_wr && in_range && (acc_word || (k == 2'd0));
			if (cmd.clear_step) begin
				bank_addr[b]  = clr_row_q;
				bank_wdata[b] = 8'h00;
				bank_we[b]    = 1'b1;
			end
		end
	end

	// Byte banks
	for (genvar g = 0; g < 4; g++) begin : g_bank
		msu_ram #(
			.WIDTH (8),
			.DEPTH (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[g]),
			.re    (cmd.accept),
			.addr  (bank_addr[g]),
			.wdata (bank_wdata[g]),
			.rdata (bank_rdata[g])
		);
	end

	// Rotate bank read data back into lane order
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			lane[k] = bank_rdata[2'(off_s1 + 2'(k))];
		end
		if (!rd_en_s1) begin
			rd_value = 32'd0;
		end else if (word_s1) begin
			rd_value = {lane[3], lane[2], lane[1], lane[0]};
		end else begin
			rd_value = {24'd0, lane[0]};
		end
	end

	assign sts.clear_last = (clr_row_q == LAST_ROW);

	// PC, SP, flags and clearing row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= 32'd0;
			sp_q      <= STACK_BASE_RESET;
			flags_q   <= 8'h00;
			clr_row_q <= '0;
		end else begin
			if (cmd.clear_step && !sts.clear_last) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
			end
			if (cfg_we) begin
				sp_q <= cfg_wdata;
			end else if (cmd.accept) begin
				sp_q <= sp_nxt;
			end
			if (cmd.accept) begin
				pc_q    <= pc_nxt;
				flags_q <= flags_nxt;
			end
		end
	end

	// Access context for the read cycle
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			off_s1   <= ea[1:0];
			word_s1  <= acc_word;
			rd_en_s1 <= acc_rd && in_range;
			bad_s1   <= (acc_rd || acc_wr) && !in_range;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			read_data_q    <= rd_value;
			out_of_range_q <= bad_s1;
			pc_out_q       <= pc_q;
			sp_out_q       <= sp_q;
			flags_out_q    <= flags_q;
		end
	end

	assign read_data       = read_data_q;
	assign out_of_range    = out_of_range_q;
	assign program_counter = pc_out_q;
	assign stack_pointer   = sp_out_q;
	assign flag_bits       = flags_out_q;

endmodule

// ----- rtl/core/vm_memory_stack_unit.sv -----
// Top level of the VM memory and stack unit.
`timescale 1ns / 1ps
// The transfer cycle of an item decodes it, updates PC, SP and flags, performs
// any write and starts the read of the four byte banks; then, in the exec
// state, once the output register is free, the registered bank data is rotated
// into place and loaded into the output register. Each bank serves one row per
// cycle, so an unaligned word spanning two rows still completes in one access. A
// new item is taken only once the previous result sits in the output register.
// After reset the block runs a clearing pass over every row of the four banks
// with in_stall high; stack_base writes are taken during it and load the stack
// pointer at once.
module vm_memory_stack_unit #(
	parameter int MEM_BYTES = msu_pkg::MEM_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [31:0] address,
	input  logic [31:0] data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        out_of_range,
	output logic [31:0] program_counter,
	output logic [31:0] stack_pointer,
	output logic [7:0]  flag_bits,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import msu_pkg::*;

	msu_cmd_t cmd;
	msu_sts_t sts;

	// Sequencing
	msu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Storage and arithmetic
	msu_datapath #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.address         (address),
		.data            (data),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.read_data       (read_data),
		.out_of_range    (out_of_range),
		.program_counter (program_counter),
		.stack_pointer   (stack_pointer),
		.flag_bits       (flag_bits)
	);

endmodule

// ----- rtl/core/msu_checker.sv -----
// Port-level checks for the VM memory and stack unit, bound to the top level.
`timescale 1ns / 1ps
module msu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [3:0]  operation,
	input logic [31:0] address,
	input logic [31:0] data,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] read_data,
	input logic        out_of_range,
	input logic [31:0] program_counter,
	input logic [31:0] stack_pointer,
	input logic [7:0]  flag_bits
);
	import msu_pkg::*;

	// One item in flight: the cycle after a transfer takes no new item
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken in the cycle after a transfer");

	// A stalled input item holds until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(operation) &&
			$stable(address) && $stable(data)))
		else $error("stalled input item changed");

	// A suppressed access never returns data
	a_bad_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_of_range) |-> (read_data == 32'd0))
		else $error("out-of-range result carries nonzero data");

	// Only sign, zero and parity flags exist, and zero excludes sign
	a_flag_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (((flag_bits & 8'h3B) == 8'h00) &&
			!(flag_bits[FLAG_SIGN] && flag_bits[FLAG_ZERO])))
		else $error("impossible flags byte");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(read_data) &&
			$stable(program_counter) && $stable(stack_pointer)))
		else $error("stalled result changed");

endmodule

bind vm_memory_stack_unit msu_checker u_msu_checker (.*);

// ----- sim/vm_memory_stack_unit_tb.sv -----
// Self-checking testbench for the VM memory and stack unit: random and directed traffic.
`timescale 1ns / 1ps
module vm_memory_stack_unit_tb;
	import msu_pkg::*;

	localparam int STORE_BYTES   = MEM_BYTES_DEFAULT;
	localparam int SETTLE_CYCLES = 3;
	localparam int TAIL_CYCLES   = 8;
	localparam int CYCLE_LIMIT   = 800000;
	localparam int SEG_ITEMS     = 150;

	typedef enum logic [1:0] {JOB_ITEM, JOB_CFG, JOB_PAUSE} job_kind_e;

	// One entry of the stimulus list: an operation, a stack_base write or a drain pause
	typedef struct packed {
		job_kind_e   kind;
		logic [3:0]  op;
		logic [31:0] addr;
		logic [31:0] dat;
		logic [6:0]  gap_pct;
		logic [6:0]  stall_pct;
	} mem_job_t;

	typedef struct packed {
		logic [31:0] rd_word;
		logic        oor;
		logic [31:0] pc;
		logic [31:0] sp;
		logic [7:0]  flags;
	} unit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  operation = '0;
	logic [31:0] address = '0;
	logic [31:0] data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic        out_of_range;
	logic [31:0] program_counter;
	logic [31:0] stack_pointer;
	logic [7:0]  flag_bits;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// Stimulus list and expected results
	mem_job_t     jobs[$];
	unit_result_t expected_q[$];
	int unsigned  items_total = 0;
	int unsigned  items_taken = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  rx_stall_pct = 0;
	logic [6:0]   gap_now = '0;
	logic [6:0]   stall_now = '0;

	// Generator's view of SP, used only to shape the traffic
	logic [31:0] gen_sp = STACK_BASE_RESET;

	// Predictor state
	logic [7:0]  shadow_mem [STORE_BYTES];
	logic [31:0] pc_model = '0;
	logic [31:0] sp_model = STACK_BASE_RESET;
	logic [7:0]  flags_model = '0;

	vm_memory_stack_unit #(
		.MEM_BYTES(STORE_BYTES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.operation      (operation),
		.address        (address),
		.data           (data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.out_of_range   (out_of_range),
		.program_counter(program_counter),
		.stack_pointer  (stack_pointer),
		.flag_bits      (flag_bits),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic byte_hit(input logic [31:0] a);
		return {1'b0, a} < 33'(STORE_BYTES);
	endfunction

	// No wrap: a word near the top of the address space is out of range
	function automatic logic word_hit(input logic [31:0] a);
		return {1'b0, a} + 33'd3 < 33'(STORE_BYTES);
	endfunction

	function automatic logic [31:0] shadow_word(input logic [31:0] a);
		return {shadow_mem[a + 3], shadow_mem[a + 2], shadow_mem[a + 1], shadow_mem[a]};
	endfunction

	task automatic put_word(input logic [31:0] a, input logic [31:0] v);
		shadow_mem[a]     = v[7:0];
		shadow_mem[a + 1] = v[15:8];
		shadow_mem[a + 2] = v[23:16];
		shadow_mem[a + 3] = v[31:24];
	endtask

	function automatic logic [7:0] flag_byte(input logic [31:0] v);
		logic [7:0] f;
		f = '0;
		f[FLAG_ZERO]   = (v == 32'd0);
		f[FLAG_SIGN]   = v[31];
		f[FLAG_PARITY] = ~^v;
		return f;
	endfunction

	// Applies one operation to the predictor state and returns the result it yields
	task automatic model_step(input logic [3:0] op, input logic [31:0] a,
			input logic [31:0] d, output unit_result_t r);
		logic [31:0] rd;
		logic        bad;
		rd = '0;
		bad = 1'b0;
		case (op)
			OP_RDBYTE: begin
				if (byte_hit(a)) rd = {24'd0, shadow_mem[a]};
				else bad = 1'b1;
			end
			OP_WRBYTE: begin
				if (byte_hit(a)) shadow_mem[a] = d[7:0];
				else bad = 1'b1;
			end
			OP_RDWORD: begin
				if (word_hit(a)) rd = shadow_word(a);
				else bad = 1'b1;
			end
			OP_WRWORD: begin
				if (word_hit(a)) put_word(a, d);
				else bad = 1'b1;
			end
			OP_FETCHB: begin
				if (byte_hit(pc_model)) rd = {24'd0, shadow_mem[pc_model]};
				else bad = 1'b1;
				pc_model = pc_model + 32'd1;
			end
			OP_FETCHW: begin
				if (word_hit(pc_model)) rd = shadow_word(pc_model);
				else bad = 1'b1;
				pc_model = pc_model + 32'd4;
			end
			OP_PUSH: begin
				sp_model = sp_model - 32'd4;
				if (word_hit(sp_model)) put_word(sp_model, d);
				else bad = 1'b1;
			end
			OP_POP: begin
				if (word_hit(sp_model)) rd = shadow_word(sp_model);
				else bad = 1'b1;
				sp_model = sp_model + 32'd4;
			end
			OP_FLAGS: flags_model = flag_byte(d);
			default: ;
		endcase
		r.rd_word = rd;
		r.oor     = bad;
		r.pc      = pc_model;
		r.sp      = sp_model;
		r.flags   = flags_model;
	endtask

	// ---------------------------------------------------------------- stimulus building

	task automatic set_idle(input int unsigned gap, input int unsigned stall);
		gap_now = 7'(gap);
		stall_now = 7'(stall);
	endtask

	task automatic add_item(input logic [3:0] op, input logic [31:0] a, input logic [31:0] d);
		mem_job_t j;
		j.kind = JOB_ITEM;
		j.op = op;
		j.addr = a;
		j.dat = d;
		j.gap_pct = gap_now;
		j.stall_pct = stall_now;
		jobs.push_back(j);
		items_total++;
		case (op)
			OP_PUSH:   gen_sp = gen_sp - 32'd4;
			OP_POP:    gen_sp = gen_sp + 32'd4;
			default: ;
		endcase
	endtask

	task automatic add_control(input job_kind_e kind, input logic [31:0] value);
		mem_job_t j;
		j = '0;
		j.kind = kind;
		j.dat = value;
		jobs.push_back(j);
		if (kind == JOB_CFG) gen_sp = value;
	endtask

	function automatic logic [31:0] pick_data();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'd1 << $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	// Mostly addresses inside the store so reads hit earlier writes
	function automatic logic [31:0] pick_addr();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 35) return $urandom_range(255);
		if (k < 50) return STORE_BYTES - 1 - $urandom_range(15);
		if (k < 65) return $urandom_range(STORE_BYTES - 1);
		if (k < 75) return STORE_BYTES + $urandom_range(63);
		if (k < 85) return gen_sp - 32'd8 + $urandom_range(16);
		if (k < 93) return $urandom();
		return 32'hFFFF_FFFF - $urandom_range(15);
	endfunction

	// One random chunk: a single operation, or a stack frame pushed, possibly peeked and overwritten, and popped
	task automatic add_random_traffic();
		int unsigned pick;
		int unsigned n;
		pick = $urandom_range(99);
		if (pick < 18) begin
			add_item($urandom_range(1) ? OP_WRWORD : OP_WRBYTE, pick_addr(), pick_data());
		end else if (pick < 36) begin
			add_item($urandom_range(1) ? OP_RDWORD : OP_RDBYTE, pick_addr(), pick_data());
		end else if (pick < 44) begin
			add_item($urandom_range(1) ? OP_FETCHW : OP_FETCHB, pick_addr(), pick_data());
		end else if (pick < 70) begin
			n = $urandom_range(4, 1);
			repeat (n) add_item(OP_PUSH, pick_addr(), pick_data());
			if ($urandom_range(1))
				add_item(OP_RDWORD, gen_sp + 32'(4 * $urandom_range(n - 1)), pick_data());
			if ($urandom_range(3) == 0)
				add_item(OP_WRWORD, gen_sp, pick_data());
			repeat ($urandom_range(n + 1, n - 1)) add_item(OP_POP, pick_addr(), pick_data());
		end else if (pick < 80) begin
			add_item(OP_FLAGS, pick_addr(), pick_data());
		end else if (pick < 86) begin
			add_item(4'($urandom_range(15, 9)), pick_addr(), pick_data());
		end else begin
			add_item(4'($urandom_range(15)), $urandom(), $urandom());
		end
	endtask

	// ---------------------------------------------------------------- driver

	always @(posedge clk) begin
		mem_job_t     head;
		unit_result_t want;
		logic         hold;
		logic         next_valid;
		logic         next_we;
		hold = in_valid && in_stall;
		next_valid = 1'b0;
		next_we = 1'b0;
		// Predict each accepted transfer
		if (in_valid && !in_stall) begin
			model_step(operation, address, data, want);
			expected_q.push_back(want);
			items_taken++;
		end
		if (arst_n && !hold && jobs.size() > 0) begin
			head = jobs[0];
			if (head.kind == JOB_ITEM) begin
				quiet_cycles = 0;
				if ($urandom_range(99) >= head.gap_pct) begin
					head = jobs.pop_front();
					operation <= head.op;
					address <= head.addr;
					data <= head.dat;
					rx_stall_pct = head.stall_pct;
					next_valid = 1'b1;
				end
			end else if (expected_q.size() != 0) begin
				quiet_cycles = 0;
			end else if (quiet_cycles < SETTLE_CYCLES) begin
				quiet_cycles++;
			end else begin
				// Block is idle: register write or end of pause
				head = jobs.pop_front();
				quiet_cycles = 0;
				if (head.kind == JOB_CFG) begin
					next_we = 1'b1;
					cfg_wdata <= head.dat;
					sp_model = head.dat;
				end
			end
		end
		if (!hold) in_valid <= next_valid;
		cfg_we <= next_we;
	end

	// ---------------------------------------------------------------- monitor

	task automatic log_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("[%0t] %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got)
			log_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
	endtask

	always @(posedge clk) begin
		unit_result_t want;
		if (out_valid === 1'b1 && !out_stall) begin
			if (expected_q.size() == 0) begin
				log_failure($sformatf("result transfer with nothing expected, read_data %h",
					read_data));
			end else begin
				want = expected_q.pop_front();
				check_field("read_data", want.rd_word, read_data);
				check_field("out_of_range", {31'd0, want.oor}, {31'd0, out_of_range});
				check_field("program_counter", want.pc, program_counter);
				check_field("stack_pointer", want.sp, stack_pointer);
				check_field("flag_bits", {24'd0, want.flags}, {24'd0, flag_bits});
			end
		end
		out_stall <= arst_n && ($urandom_range(99) < rx_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		logic [31:0] seg_base [8];
		int unsigned seg_start;
		for (int i = 0; i < STORE_BYTES; i++) shadow_mem[i] = 8'h00;

		// Directed: flags, endianness, store edges, fetch, stack, unused codes
		set_idle(6, 74);
		add_control(JOB_CFG, STACK_BASE_RESET);
		add_item(OP_FLAGS, 32'd0, 32'd0);
		add_item(OP_FLAGS, 32'd0, 32'h8000_0000);
		add_item(OP_FLAGS, 32'd0, 32'hFFFF_FFFF);
		add_item(OP_WRWORD, 32'd0, 32'hDEAD_BEEF);
		add_item(OP_RDBYTE, 32'd3, 32'd0);
		add_item(OP_WRBYTE, 32'd1, 32'hFFFF_FF5A);
		add_item(OP_RDWORD, 32'd0, 32'd0);
		add_item(OP_WRWORD, STORE_BYTES - 4, 32'h89AB_CDEF);
		add_item(OP_RDWORD, STORE_BYTES - 4, 32'd0);
		add_item(OP_WRWORD, STORE_BYTES - 3, 32'h1234_5678);
		add_item(OP_RDWORD, STORE_BYTES - 3, 32'd0);
		add_item(OP_RDBYTE, STORE_BYTES - 1, 32'd0);
		add_item(OP_WRBYTE, STORE_BYTES, 32'h0000_00A5);
		add_item(OP_RDBYTE, STORE_BYTES, 32'd0);
		add_item(OP_RDBYTE, 32'hFFFF_FFFF, 32'd0);
		add_item(OP_RDWORD, 32'hFFFF_FFFD, 32'd0);
		add_item(OP_WRWORD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		add_item(OP_FETCHB, 32'd0, 32'd0);
		add_item(OP_FETCHW, 32'd0, 32'd0);
		add_item(OP_PUSH, 32'd0, 32'h0BAD_F00D);
		add_item(OP_POP, 32'd0, 32'd0);
		add_item(OP_POP, 32'd0, 32'd0);
		add_item(OP_PUSH, 32'd0, 32'h5555_AAAA);
		add_item(4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_item(4'd15, 32'd0, 32'd0);

		// Random segments, each under its own stack_base
		seg_base[0] = 32'd0;
		seg_base[1] = 32'hFFFF_FFFF;
		seg_base[2] = STORE_BYTES - 2;
		seg_base[3] = $urandom_range(STORE_BYTES - 4, 64);
		seg_base[4] = $urandom();
		seg_base[5] = STACK_BASE_RESET;
		seg_base[6] = 32'd16;
		seg_base[7] = $urandom_range(STORE_BYTES - 4, 64);
		for (int seg = 0; seg < 8; seg++) begin
			if (seg < 4) set_idle(6, 74);
			else if (seg < 7) set_idle(74, 6);
			else set_idle(0, 0);
			add_control(JOB_CFG, seg_base[seg]);
			seg_start = items_total;
			for (int n = 0; n < SEG_ITEMS; n = int'(items_total - seg_start)) begin
				if (seg % 3 == 2 && n >= SEG_ITEMS / 2 && n < SEG_ITEMS / 2 + 3)
					add_control(JOB_PAUSE, '0);
				add_random_traffic();
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (jobs.size() != 0 || items_taken != items_total || expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- vm_memory_stack_unit.f -----
rtl/core/msu_pkg.sv
rtl/core/msu_ram.sv
rtl/core/msu_ctrl.sv
rtl/core/msu_datapath.sv
rtl/core/vm_memory_stack_unit.sv
rtl/core/msu_checker.sv
sim/vm_memory_stack_unit_tb.sv
